// ----- design/life_cellular_automaton_grid_macros.svh -----
// ----------------------------------------------------------------------------
// life_cellular_automaton_grid_macros.svh
// Assertion macros shared by the checker of the life grid block.
// ----------------------------------------------------------------------------
`ifndef LIFE_CELLULAR_AUTOMATON_GRID_MACROS_SVH
`define LIFE_CELLULAR_AUTOMATON_GRID_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define LCAG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lcag check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define LCAG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lcag check failed");

`endif

// ----- design/lcag_pkg.sv -----
// ----------------------------------------------------------------------------
// lcag_pkg
// Operation codes, controller commands and the cell update rule.
// ----------------------------------------------------------------------------
package lcag_pkg;

  // Operation selected by the func field
  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_STEP  = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_e;

  // Commands from controller to datapath, one-hot or all low
  typedef struct packed {
    logic wr;
    logic step;
    logic rd;
    logic clr;
  } cmd_t;

  // Next state of one cell from its eight neighbors and its own state
  function automatic logic life_rule(input logic [7:0] nb, input logic self);
    logic [3:0] cnt;
    cnt = 4'($countones(nb));
    return (cnt == 4'd3) || ((cnt == 4'd2) && self);
  endfunction

endpackage

// ----- design/lcag_ctrl.sv -----
// ----------------------------------------------------------------------------
// lcag_ctrl
// Handshake controller: decodes accepted beats into datapath commands and
// tracks the occupancy of the read result register.
// ----------------------------------------------------------------------------
module lcag_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  input  logic [1:0]        func_i,
  input  logic              m_ready_i,
  output logic              s_ready_o,
  output logic              m_valid_o,
  output lcag_pkg::cmd_t    cmd_o
);

  typedef enum logic {
    ST_EMPTY,
    ST_FULL
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  // Take a beat when the result slot is free or drains this cycle
  assign s_ready_o = (state_q == ST_EMPTY) || m_ready_i;
  assign accept    = s_valid_i && s_ready_o;
  assign m_valid_o = (state_q == ST_FULL);

  // Command decode
  always_comb begin
    cmd_o = '0;
    if (accept) begin
      case (func_i)
        lcag_pkg::FUNC_WRITE: cmd_o.wr   = 1'b1;
        lcag_pkg::FUNC_STEP:  cmd_o.step = 1'b1;
        lcag_pkg::FUNC_READ:  cmd_o.rd   = 1'b1;
        lcag_pkg::FUNC_CLEAR: cmd_o.clr  = 1'b1;
        default:              cmd_o      = '0;
      endcase
    end
  end

  // Result slot occupancy
  always_comb begin
    state_d = state_q;
    if (cmd_o.rd) begin
      state_d = ST_FULL;
    end else if (m_ready_i) begin
      state_d = ST_EMPTY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_EMPTY;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- design/lcag_dp.sv -----
// ----------------------------------------------------------------------------
// lcag_dp
// Cell grid datapath: one flop per cell, per-cell next-generation logic,
// single-cell write, clear, and a registered row read.
// ----------------------------------------------------------------------------
module lcag_dp #(
  parameter int ROWS = 16,
  parameter int COLS = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lcag_pkg::cmd_t cmd_i,
  input  logic [3:0]     cell_row_i,
  input  logic [4:0]     cell_col_i,
  input  logic           alive_i,
  output logic [31:0]    row_bits_o
);

  localparam int RowW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int ColW = (COLS > 1) ? $clog2(COLS) : 1;

  logic [COLS-1:0] grid_q [ROWS];
  logic [COLS-1:0] next_gen [ROWS];
  logic [RowW-1:0] row_idx;
  logic [ColW-1:0] col_idx;
  logic            row_ok;
  logic            col_ok;
  logic [COLS-1:0] rd_row;
  logic [63:0]     rd_wide;
  logic [31:0]     rd_data_q;

  // Address decode and range checks
  assign row_idx = RowW'(cell_row_i);
  assign col_idx = ColW'(cell_col_i);
  assign row_ok  = (32'(cell_row_i) < 32'(ROWS));
  assign col_ok  = (32'(cell_col_i) < 32'(COLS));

  // Next generation: dead border around the grid, every cell in parallel
  always_comb begin
    logic [COLS+1:0] pad [ROWS+2];
    logic [7:0]      nb;
    nb = '0;
    for (int r = 0; r < ROWS + 2; r++) begin
      pad[r] = '0;
    end
    for (int r = 0; r < ROWS; r++) begin
      pad[r+1] = {1'b0, grid_q[r], 1'b0};
    end
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLS; c++) begin
        nb = {pad[r][c],   pad[r][c+1],   pad[r][c+2],
              pad[r+1][c],                pad[r+1][c+2],
              pad[r+2][c], pad[r+2][c+1], pad[r+2][c+2]};
        next_gen[r][c] = lcag_pkg::life_rule(nb, grid_q[r][c]);
      end
    end
  end

  // Grid state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ROWS; r++) begin
        grid_q[r] <= '0;
      end
    end else if (cmd_i.clr) begin
      for (int r = 0; r < ROWS; r++) begin
        grid_q[r] <= '0;
      end
    end else if (cmd_i.step) begin
      for (int r = 0; r < ROWS; r++) begin
        grid_q[r] <= next_gen[r];
      end
    end else if (cmd_i.wr && row_ok && col_ok) begin
      grid_q[row_idx][col_idx] <= alive_i;
    end
  end

  // Row read, rows beyond the grid read as all dead
  assign rd_row  = row_ok ? grid_q[row_idx] : '0;
  assign rd_wide = 64'(rd_row);

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rd_data_q <= rd_wide[31:0];
    end
  end

  assign row_bits_o = rd_data_q;

endmodule

// ----- design/life_cellular_automaton_grid.sv -----
// Read: a read row beat shows its result on m_axis in the cycle after accept.
// Throughput: one beat per cycle while not stalled; a generation advance updates
// every cell at once through the per-cell next-state logic.
// Input stalls only while a read result waits and m_axis_tready is low.
// Reset: asynchronous, active low; clears every cell and the result slot.
// ----------------------------------------------------------------------------
// life_cellular_automaton_grid
// Game of life grid with cell write, clear, generation step and row read.
// ----------------------------------------------------------------------------
module life_cellular_automaton_grid #(
  parameter int ROWS = 16,
  parameter int COLS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] func, [5:2] cell_row, [10:6] cell_col, [11] alive, [15:12] zero
  input  logic [15:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] row_bits
  output logic [31:0] m_axis_tdata
);

  lcag_pkg::cmd_t cmd;

  lcag_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .func_i    (s_axis_tdata[1:0]),
    .m_ready_i (m_axis_tready),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .cmd_o     (cmd)
  );

  lcag_dp #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cell_row_i (s_axis_tdata[5:2]),
    .cell_col_i (s_axis_tdata[10:6]),
    .alive_i    (s_axis_tdata[11]),
    .row_bits_o (m_axis_tdata)
  );

endmodule

// ----- design/lcag_checker.sv -----
// ----------------------------------------------------------------------------
// lcag_checker
// Port-level checks for the life grid block, bound to the top level.
// ----------------------------------------------------------------------------
`include "life_cellular_automaton_grid_macros.svh"

module lcag_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [15:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  logic       acc;
  logic [1:0] func;
  logic [3:0] row;
  logic [4:0] col;
  logic       alive;
  logic       rd_acc;
  logic       clr_acc;
  logic       wr_near;

  // Input beat fields
  assign acc   = s_axis_tvalid && s_axis_tready;
  assign func  = s_axis_tdata[1:0];
  assign row   = s_axis_tdata[5:2];
  assign col   = s_axis_tdata[10:6];
  assign alive = s_axis_tdata[11];

  // Accepted beats by operation; near writes hit the grid if it has three rows and columns
  assign rd_acc  = acc && (func == lcag_pkg::FUNC_READ);
  assign clr_acc = acc && (func == lcag_pkg::FUNC_CLEAR);
  assign wr_near = acc && (func == lcag_pkg::FUNC_WRITE) && (row < 4'd3) && (col < 5'd3);

  // Write followed at once by a read of the same row
  sequence s_wr_then_rd;
    wr_near ##1 (rd_acc && (row == $past(row)));
  endsequence

  // A stalled result beat holds
  `LCAG_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // Every accepted read gives a result beat next cycle
  `LCAG_ASSERT_NEXT(a_read_result, rd_acc, m_axis_tvalid)

  // A cell written and read back at once shows the written value
  `LCAG_ASSERT_NEXT(a_write_read, s_wr_then_rd, m_axis_tdata[$past(col, 2)] == $past(alive, 2))

  // A read right after a clear shows an empty row
  `LCAG_ASSERT_NEXT(a_clear_read, clr_acc ##1 rd_acc, m_axis_tdata == 32'd0)

endmodule

bind life_cellular_automaton_grid lcag_checker u_lcag_checker (.*);

// ----- test/tb_life_cellular_automaton_grid.sv -----
// ----------------------------------------------------------------------------
// tb_life_cellular_automaton_grid
// Drives cell writes, clears, generation steps and row reads into the life
// grid over the input stream and checks every row beat on the output stream
// against a cell-level model of the grid kept by a small scoreboard.
// ----------------------------------------------------------------------------
module tb_life_cellular_automaton_grid;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROWS      = 16;
  localparam int COLS      = 32;
  localparam int NUM_BEATS = 1950;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // [1:0] func, [5:2] cell_row, [10:6] cell_col, [11] alive, [15:12] zero
  logic [15:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // [31:0] row_bits
  logic [31:0] m_axis_tdata;

  // Grid model and queue of row beats still owed by the block
  class life_grid_scoreboard;
    logic [COLS-1:0] cells [ROWS];
    logic [31:0]     row_queue [$];
    int unsigned     errors;

    function new();
      clear_cells();
      errors = 0;
    endfunction

    function void clear_cells();
      foreach (cells[r]) cells[r] = '0;
    endfunction

    // Cells off the edge read as dead
    function logic cell_at(int r, int c);
      if (r < 0 || r >= ROWS || c < 0 || c >= COLS) return 1'b0;
      return cells[r][c];
    endfunction

    // Whole grid moves to the next generation at once
    function void step_generation();
      logic [COLS-1:0] nxt [ROWS];
      int              cnt;
      for (int r = 0; r < ROWS; r++) begin
        for (int c = 0; c < COLS; c++) begin
          cnt = 0;
          for (int dr = -1; dr <= 1; dr++)
            for (int dc = -1; dc <= 1; dc++)
              if (dr != 0 || dc != 0) cnt += cell_at(r + dr, c + dc);
          nxt[r][c] = (cnt == 3) || ((cnt == 2) && cells[r][c]);
        end
      end
      cells = nxt;
    endfunction

    // Apply one accepted input beat
    function void note_beat(logic [15:0] beat);
      lcag_pkg::func_e op;
      logic [3:0]      r;
      logic [4:0]      c;
      logic            a;
      op = lcag_pkg::func_e'(beat[1:0]);
      r  = beat[5:2];
      c  = beat[10:6];
      a  = beat[11];
      case (op)
        lcag_pkg::FUNC_WRITE: begin
          if (int'(r) < ROWS && int'(c) < COLS) cells[r][c] = a;
        end
        lcag_pkg::FUNC_STEP:  step_generation();
        lcag_pkg::FUNC_READ: begin
          if (int'(r) < ROWS) row_queue.push_back(32'(cells[r]));
          else row_queue.push_back('0);
        end
        default:    clear_cells();
      endcase
    endfunction

    // Compare one output beat against the oldest owed row
    function void check_row(logic [31:0] got);
      logic [31:0] want;
      if (row_queue.size() == 0) begin
        $display("%0t: unexpected row beat, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = row_queue.pop_front();
      if (got !== want) begin
        $display("%0t: row_bits mismatch, expected %h, actual %h", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  life_grid_scoreboard sb;
  int unsigned         beats_sent;
  bit                  tx_burst;
  bit                  rx_burst;
  int unsigned         rx_stall;

  life_cellular_automaton_grid #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Safety net
  initial begin
    #5ms;
    $display("** life_cellular_automaton_grid: FAILED **");
    $finish;
  end

  // Output monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_row(m_axis_tdata);
  end

  // Receiver back-pressure, with stall-free stretches
  initial begin
    m_axis_tready = 1'b0;
    rx_stall      = 0;
    rx_burst      = 1'b0;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 199) == 0) rx_burst = ~rx_burst;
      if (rx_stall > 0) begin
        m_axis_tready = 1'b0;
        rx_stall--;
      end else begin
        m_axis_tready = 1'b1;
        if (!rx_burst) begin
          case ($urandom_range(0, 19))
            0, 1, 2, 3, 4: rx_stall = $urandom_range(1, 3);
            5:             rx_stall = $urandom_range(10, 30);
            default:       rx_stall = 0;
          endcase
        end
      end
    end
  end

  // Sender gap after a beat: mostly none, some short, a few long
  task automatic idle_gap();
    int unsigned n;
    if (tx_burst) return;
    case ($urandom_range(0, 19))
      0, 1, 2, 3: n = $urandom_range(1, 3);
      4:          n = $urandom_range(10, 30);
      default:    n = 0;
    endcase
    if (n == 0) return;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  // One input beat, held until accepted
  task automatic send_beat(lcag_pkg::func_e op, logic [3:0] r, logic [4:0] c, logic a);
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {4'b0000, a, c, r, op};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_beat(s_axis_tdata);
    beats_sent++;
    idle_gap();
  endtask

  task automatic hold_until_drained();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (sb.row_queue.size() != 0) @(posedge clk_i);
  endtask

  // Cluster of writes near a spot, then a few generations with reads around it
  task automatic pattern_episode();
    logic [3:0]  br;
    logic [4:0]  bc;
    int unsigned n;
    n  = $urandom_range(4, 16);
    br = 4'($urandom_range(0, 15));
    bc = 5'($urandom_range(0, 31));
    repeat (n)
      send_beat(lcag_pkg::FUNC_WRITE, br + 4'($urandom_range(0, 3)),
                bc + 5'($urandom_range(0, 3)), $urandom_range(0, 9) < 7);
    repeat ($urandom_range(1, 5)) begin
      send_beat(lcag_pkg::FUNC_STEP, 4'($urandom), 5'($urandom), 1'($urandom));
      repeat ($urandom_range(1, 3))
        send_beat(lcag_pkg::FUNC_READ, br - 4'd1 + 4'($urandom_range(0, 5)),
                  5'($urandom), 1'($urandom));
    end
  endtask

  // Fully random beats
  task automatic noise_episode();
    repeat ($urandom_range(5, 15)) begin
      case ($urandom_range(0, 19))
        0:       send_beat(lcag_pkg::FUNC_CLEAR, 4'($urandom), 5'($urandom), 1'($urandom));
        1, 2, 3: send_beat(lcag_pkg::FUNC_STEP, 4'($urandom), 5'($urandom), 1'($urandom));
        4, 5, 6, 7, 8:
                 send_beat(lcag_pkg::FUNC_READ, 4'($urandom), 5'($urandom), 1'($urandom));
        default: send_beat(lcag_pkg::FUNC_WRITE, 4'($urandom), 5'($urandom), 1'($urandom));
      endcase
    end
  endtask

  task automatic read_all_rows();
    for (int r = 0; r < ROWS; r++)
      send_beat(lcag_pkg::FUNC_READ, 4'(r), 5'($urandom), 1'($urandom));
  endtask

  // Main sequence
  initial begin
    int unsigned waited;
    bit          drained_once;
    sb            = new();
    beats_sent    = 0;
    tx_burst      = 1'b0;
    drained_once  = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    rst_ni        = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: corners, kill a cell, blinker, still block, clear
    send_beat(lcag_pkg::FUNC_READ, 4'd0, 5'd31, 1'b1);
    send_beat(lcag_pkg::FUNC_WRITE, 4'd0, 5'd0, 1'b1);
    send_beat(lcag_pkg::FUNC_WRITE, 4'd15, 5'd31, 1'b1);
    send_beat(lcag_pkg::FUNC_WRITE, 4'd0, 5'd31, 1'b1);
    send_beat(lcag_pkg::FUNC_WRITE, 4'd15, 5'd0, 1'b1);
    send_beat(lcag_pkg::FUNC_READ, 4'd0, 5'd0, 1'b0);
    send_beat(lcag_pkg::FUNC_READ, 4'd15, 5'd0, 1'b0);
    send_beat(lcag_pkg::FUNC_WRITE, 4'd0, 5'd0, 1'b0);
    send_beat(lcag_pkg::FUNC_READ, 4'd0, 5'd0, 1'b0);
    send_beat(lcag_pkg::FUNC_WRITE, 4'd7, 5'd10, 1'b1);
    send_beat(lcag_pkg::FUNC_WRITE, 4'd7, 5'd11, 1'b1);
    send_beat(lcag_pkg::FUNC_WRITE, 4'd7, 5'd12, 1'b1);
    send_beat(lcag_pkg::FUNC_WRITE, 4'd1, 5'd20, 1'b1);
    send_beat(lcag_pkg::FUNC_WRITE, 4'd1, 5'd21, 1'b1);
    send_beat(lcag_pkg::FUNC_WRITE, 4'd2, 5'd20, 1'b1);
    send_beat(lcag_pkg::FUNC_WRITE, 4'd2, 5'd21, 1'b1);
    send_beat(lcag_pkg::FUNC_STEP, 4'd0, 5'd0, 1'b0);
    send_beat(lcag_pkg::FUNC_READ, 4'd6, 5'd0, 1'b0);
    send_beat(lcag_pkg::FUNC_READ, 4'd8, 5'd0, 1'b0);
    send_beat(lcag_pkg::FUNC_STEP, 4'hf, 5'h1f, 1'b1);
    send_beat(lcag_pkg::FUNC_READ, 4'd7, 5'd0, 1'b0);
    send_beat(lcag_pkg::FUNC_READ, 4'd1, 5'd0, 1'b0);
    send_beat(lcag_pkg::FUNC_CLEAR, 4'hf, 5'h1f, 1'b1);
    send_beat(lcag_pkg::FUNC_READ, 4'd15, 5'd0, 1'b0);
    hold_until_drained();

    // Random: mostly pattern growth and evolution, some noise and sweeps
    while (beats_sent < NUM_BEATS) begin
      tx_burst = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9))
        6, 7:    noise_episode();
        8:       read_all_rows();
        9: begin
          send_beat(lcag_pkg::FUNC_CLEAR, 4'($urandom), 5'($urandom), 1'($urandom));
          pattern_episode();
        end
        default: pattern_episode();
      endcase
      if (!drained_once && beats_sent > NUM_BEATS / 2) begin
        hold_until_drained();
        drained_once = 1'b1;
      end
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;

    // Drain, then let the output settle
    waited = 0;
    while (sb.row_queue.size() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (10) @(posedge clk_i);
    if (sb.row_queue.size() != 0) begin
      $display("%0t: %0d row beats never arrived", $time, sb.row_queue.size());
      sb.errors++;
    end

    if (sb.errors == 0) begin
      $display("** life_cellular_automaton_grid: PASSED **");
    end else begin
      $display("** life_cellular_automaton_grid: FAILED **");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/lcag_pkg.sv
design/lcag_ctrl.sv
design/lcag_dp.sv
design/life_cellular_automaton_grid.sv
design/lcag_checker.sv
test/tb_life_cellular_automaton_grid.sv
